/* rtl/core/tga_pkg.sv */
// Shared types and constants for the TGA pixel decoder.
`default_nettype none

package tga_pkg;

  // Pixel format codes; codes 6 and 7 decode as bgr24.
  localparam logic [2:0] FMT_INDEX8 = 3'd0;
  localparam logic [2:0] FMT_BGR15  = 3'd1;
  localparam logic [2:0] FMT_BGR24  = 3'd2;
  localparam logic [2:0] FMT_BGRA32 = 3'd3;
  localparam logic [2:0] FMT_GRAY8  = 3'd4;
  localparam logic [2:0] FMT_GRAYA  = 3'd5;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RLE_ENABLE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_TOTAL  = 2'd2;

  localparam logic [2:0]  FMT_RESET   = FMT_BGR24;
  localparam logic [23:0] TOTAL_RESET = 24'd1;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_PALETTE = 1'b1
  } item_kind_t;

  typedef enum logic {
    OP_PAL_WRITE = 1'b0,
    OP_PIXEL     = 1'b1
  } op_kind_t;

  // One queued operation for the back end.
  typedef struct packed {
    op_kind_t    kind;
    logic [2:0]  fmt;
    logic [23:0] partial;
    logic [7:0]  last_byte;
    logic [7:0]  rep;
    logic        last_pixel;
    logic [7:0]  pal_index;
    logic [23:0] pal_bgr;
  } op_t;

endpackage

`default_nettype wire

/* rtl/core/tga_rle_pixel_decoder.sv */
// A finished pixel passes the operation queue, stage one and the output register to out_valid.
// Throughput: one word per cycle on the input side while the queue is not full; the
// output register and a two-entry operation queue let both sides stall independently.
// Palette reads go through one registered RAM port, one read per pixel.
// Reset: synchronous; config returns to bgr24, raw, one pixel, and data words are
// dropped until the first register write. Palette contents are not cleared.
`default_nettype none

module tga_rle_pixel_decoder #(
  parameter int unsigned PALETTE_ENTRIES = 256,
  parameter int unsigned COUNT_WIDTH     = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tga_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [23:0]                     cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_kind,
  input  wire logic [7:0]                      in_data_byte,
  input  wire logic [7:0]                      in_palette_index,
  input  wire logic [23:0]                     in_palette_bgr,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [7:0]                           out_chan0,
  output logic [7:0]                           out_chan1,
  output logic [7:0]                           out_chan2,
  output logic [7:0]                           out_chan3,
  output logic [7:0]                           out_repeat_res,
  output logic                                 out_last_pixel
);

  logic         q_not_full;
  logic         q_not_empty;
  logic         q_push;
  logic         q_pop;
  tga_pkg::op_t q_push_op;
  tga_pkg::op_t q_head;

  assign cfg_ready = 1'b1;
  assign in_ready  = q_not_full;

  tga_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_accept        (in_valid && q_not_full),
    .in_kind          (in_kind),
    .in_data_byte     (in_data_byte),
    .in_palette_index (in_palette_index),
    .in_palette_bgr   (in_palette_bgr),
    .push             (q_push),
    .push_op          (q_push_op)
  );

  tga_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_op   (q_push_op),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_op   (q_head)
  );

  tga_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_chan0      (out_chan0),
    .out_chan1      (out_chan1),
    .out_chan2      (out_chan2),
    .out_chan3      (out_chan3),
    .out_repeat_res (out_repeat_res),
    .out_last_pixel (out_last_pixel)
  );

endmodule

`default_nettype wire

/* rtl/core/tga_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tga_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/core/tga_queue.sv */
// Two-entry operation queue between the front and back ends.
`default_nettype none

module tga_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire tga_pkg::op_t push_op,
  output logic              not_full,
  input  wire logic         pop,
  output logic              not_empty,
  output tga_pkg::op_t      head_op
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  tga_pkg::op_t           slot_r [DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]         count_r, count_nxt;

  assign not_full  = (count_r != (PTR_W+1)'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_op   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tga_front.sv */
// Front end: configuration, packet and byte tracking, operation issue.
`default_nettype none

module tga_front #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  input  wire logic [tga_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [23:0]                     cfg_data,
  input  wire logic                            in_accept,
  input  wire logic                            in_kind,
  input  wire logic [7:0]                      in_data_byte,
  input  wire logic [7:0]                      in_palette_index,
  input  wire logic [23:0]                     in_palette_bgr,
  output logic                                 push,
  output tga_pkg::op_t                         push_op
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  function automatic logic [2:0] bytes_per_pixel(input logic [2:0] fmt);
    logic [2:0] bpp;
    case (fmt)
      tga_pkg::FMT_INDEX8: bpp = 3'd1;
      tga_pkg::FMT_BGR15:  bpp = 3'd2;
      tga_pkg::FMT_BGRA32: bpp = 3'd4;
      tga_pkg::FMT_GRAY8:  bpp = 3'd1;
      tga_pkg::FMT_GRAYA:  bpp = 3'd2;
      default:             bpp = 3'd3;
    endcase
    return bpp;
  endfunction

  logic [2:0]             fmt_r, fmt_nxt;
  logic                   rle_r, rle_nxt;
  logic [23:0]            total_r, total_nxt;
  logic                   expect_hdr_r, expect_hdr_nxt;
  logic [7:0]             pkt_left_r, pkt_left_nxt;
  logic                   pkt_run_r, pkt_run_nxt;
  logic [1:0]             phase_r, phase_nxt;
  logic [23:0]            partial_r, partial_nxt;
  logic [COUNT_WIDTH-1:0] pix_left_r, pix_left_nxt;
  logic                   cfg_hit;
  logic [7:0]             rep;
  logic [7:0]             pkt_after;
  logic [COUNT_WIDTH-1:0] pix_after;

  assign cfg_hit = cfg_valid && (cfg_index == tga_pkg::CFG_PIXEL_FORMAT ||
                                 cfg_index == tga_pkg::CFG_RLE_ENABLE ||
                                 cfg_index == tga_pkg::CFG_PIXEL_TOTAL);

  always_comb begin
    fmt_nxt        = fmt_r;
    rle_nxt        = rle_r;
    total_nxt      = total_r;
    expect_hdr_nxt = expect_hdr_r;
    pkt_left_nxt   = pkt_left_r;
    pkt_run_nxt    = pkt_run_r;
    phase_nxt      = phase_r;
    partial_nxt    = partial_r;
    pix_left_nxt   = pix_left_r;
    rep            = 8'd1;
    pkt_after      = pkt_left_r;
    pix_after      = pix_left_r;
    push           = 1'b0;

    push_op            = '0;
    push_op.kind       = tga_pkg::OP_PIXEL;
    push_op.fmt        = fmt_r;
    push_op.partial    = partial_r;
    push_op.last_byte  = in_data_byte;
    push_op.pal_index  = in_palette_index;
    push_op.pal_bgr    = in_palette_bgr;

    if (in_accept) begin
      if (in_kind == tga_pkg::KIND_PALETTE) begin
        push         = 1'b1;
        push_op.kind = tga_pkg::OP_PAL_WRITE;
      end else if (pix_left_r != '0) begin
        if (rle_r && expect_hdr_r) begin
          pkt_left_nxt   = {1'b0, in_data_byte[6:0]} + 8'd1;
          pkt_run_nxt    = in_data_byte[7];
          expect_hdr_nxt = 1'b0;
          phase_nxt      = '0;
          partial_nxt    = '0;
        end else if (({1'b0, phase_r} + 3'd1) < bytes_per_pixel(fmt_r)) begin
          // accumulate a leading byte of the pixel
          case (phase_r)
            2'd0:    partial_nxt[7:0]   = in_data_byte;
            2'd1:    partial_nxt[15:8]  = in_data_byte;
            2'd2:    partial_nxt[23:16] = in_data_byte;
            default: partial_nxt        = partial_r;
          endcase
          phase_nxt = phase_r + 2'd1;
        end else begin
          phase_nxt   = '0;
          partial_nxt = '0;
          if (rle_r) begin
            if (pkt_run_r) begin
              // clamp the run to the pixels left
              rep = (32'(pix_left_r) < 32'(pkt_left_r)) ? pix_left_r[7:0] : pkt_left_r;
              pkt_after = '0;
            end else begin
              pkt_after = (pkt_left_r != '0) ? pkt_left_r - 8'd1 : '0;
            end
            pkt_left_nxt = pkt_after;
            if (pkt_after == '0) begin
              expect_hdr_nxt = 1'b1;
            end
          end
          pix_after    = pix_left_r - COUNT_WIDTH'(rep);
          pix_left_nxt = pix_after;
          if (pix_after == '0) begin
            expect_hdr_nxt = 1'b1;
            pkt_left_nxt   = '0;
          end
          push               = 1'b1;
          push_op.rep        = rep;
          push_op.last_pixel = (pix_after == '0);
        end
      end
    end

    // a register write restarts decoding
    if (cfg_hit) begin
      case (cfg_index)
        tga_pkg::CFG_PIXEL_FORMAT: fmt_nxt   = cfg_data[2:0];
        tga_pkg::CFG_RLE_ENABLE:   rle_nxt   = cfg_data[0];
        tga_pkg::CFG_PIXEL_TOTAL:  total_nxt = cfg_data;
        default:                   fmt_nxt   = fmt_r;
      endcase
      expect_hdr_nxt = 1'b1;
      pkt_left_nxt   = '0;
      pkt_run_nxt    = 1'b0;
      phase_nxt      = '0;
      partial_nxt    = '0;
      pix_left_nxt   = (32'(total_nxt) > 32'(COUNT_MAX)) ? COUNT_MAX
                                                         : COUNT_WIDTH'(total_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r        <= tga_pkg::FMT_RESET;
      rle_r        <= 1'b0;
      total_r      <= tga_pkg::TOTAL_RESET;
      expect_hdr_r <= 1'b1;
      pkt_left_r   <= '0;
      pkt_run_r    <= 1'b0;
      phase_r      <= '0;
      partial_r    <= '0;
      pix_left_r   <= '0;
    end else begin
      fmt_r        <= fmt_nxt;
      rle_r        <= rle_nxt;
      total_r      <= total_nxt;
      expect_hdr_r <= expect_hdr_nxt;
      pkt_left_r   <= pkt_left_nxt;
      pkt_run_r    <= pkt_run_nxt;
      phase_r      <= phase_nxt;
      partial_r    <= partial_nxt;
      pix_left_r   <= pix_left_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tga_back.sv */
// Back end: palette storage, channel forming and output register.
`default_nettype none

module tga_back #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_not_empty,
  input  wire tga_pkg::op_t q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [7:0]        out_chan0,
  output logic [7:0]        out_chan1,
  output logic [7:0]        out_chan2,
  output logic [7:0]        out_chan3,
  output logic [7:0]        out_repeat_res,
  output logic              out_last_pixel
);

  localparam int unsigned ADDR_W = $clog2(PALETTE_ENTRIES);

  logic         s1_valid_r, s1_valid_nxt;
  tga_pkg::op_t s1_op_r;
  logic         s1_hit_r;
  logic         s1_adv;
  logic         head_hit;
  logic         pop_write;
  logic         pop_pixel;
  logic [23:0]  pal_rdata;
  logic [7:0]   ch0, ch1, ch2, ch3;
  logic         out_valid_r, out_valid_nxt;
  logic [7:0]   ch0_r, ch1_r, ch2_r, ch3_r, rep_r;
  logic         last_r;
  logic [23:0]  entry;

  assign head_hit = (32'(q_head.pal_index) < PALETTE_ENTRIES);
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);

  // palette writes never wait on the output side
  assign q_pop = q_not_empty && (q_head.kind == tga_pkg::OP_PAL_WRITE ||
                                 !s1_valid_r || s1_adv);
  assign pop_write = q_pop && (q_head.kind == tga_pkg::OP_PAL_WRITE);
  assign pop_pixel = q_pop && (q_head.kind == tga_pkg::OP_PIXEL);

  tga_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (pop_write && head_hit),
    .waddr (q_head.pal_index[ADDR_W-1:0]),
    .wdata (q_head.pal_bgr),
    .re    (pop_pixel),
    .raddr (q_head.last_byte[ADDR_W-1:0]),
    .rdata (pal_rdata)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (pop_pixel) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // form channels of the pixel held in stage one
  always_comb begin
    entry = s1_hit_r ? pal_rdata : '0;
    ch0   = '0;
    ch1   = '0;
    ch2   = '0;
    ch3   = '0;
    case (s1_op_r.fmt)
      tga_pkg::FMT_INDEX8: begin
        ch0 = entry[23:16];
        ch1 = entry[15:8];
        ch2 = entry[7:0];
      end
      tga_pkg::FMT_BGR15: begin
        // word is {last byte, first byte}; bit 15 unused
        ch0 = {s1_op_r.last_byte[6:2], 3'b000};
        ch1 = {s1_op_r.last_byte[1:0], s1_op_r.partial[7:5], 3'b000};
        ch2 = {s1_op_r.partial[4:0], 3'b000};
      end
      tga_pkg::FMT_BGRA32: begin
        ch0 = s1_op_r.partial[23:16];
        ch1 = s1_op_r.partial[15:8];
        ch2 = s1_op_r.partial[7:0];
        ch3 = s1_op_r.last_byte;
      end
      tga_pkg::FMT_GRAY8: begin
        ch0 = s1_op_r.last_byte;
      end
      tga_pkg::FMT_GRAYA: begin
        ch0 = s1_op_r.partial[7:0];
        ch1 = s1_op_r.last_byte;
      end
      default: begin
        ch0 = s1_op_r.last_byte;
        ch1 = s1_op_r.partial[15:8];
        ch2 = s1_op_r.partial[7:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_pixel) begin
      s1_op_r  <= q_head;
      s1_hit_r <= (32'(q_head.last_byte) < PALETTE_ENTRIES);
    end
    if (s1_adv) begin
      ch0_r  <= ch0;
      ch1_r  <= ch1;
      ch2_r  <= ch2;
      ch3_r  <= ch3;
      rep_r  <= s1_op_r.rep;
      last_r <= s1_op_r.last_pixel;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_chan0      = ch0_r;
  assign out_chan1      = ch1_r;
  assign out_chan2      = ch2_r;
  assign out_chan3      = ch3_r;
  assign out_repeat_res = rep_r;
  assign out_last_pixel = last_r;

endmodule

`default_nettype wire
